// ===== hdl/hbop_pkg.sv =====
// Shared constants, codes and types of the hash bucket occupancy profiler.
`default_nettype none

package hbop_pkg;

    localparam int BUCKET_COUNT = 4177;
    localparam int MAX_CHAIN    = 64;
    localparam int DIGIT_BASE   = 10;

    localparam int FUNC_W  = 2;
    localparam int VAL_W   = 8;
    localparam int MODE_W  = 2;
    localparam int BKT_W   = $clog2(BUCKET_COUNT);
    localparam int LEN_W   = $clog2(MAX_CHAIN + 1);
    localparam int CNT_W   = $clog2(BUCKET_COUNT + 1);
    localparam int HIST_AW = $clog2(MAX_CHAIN + 1);

    localparam int VAL_MAX    = (1 << VAL_W) - 1;
    localparam int ACC_W      = $clog2((BUCKET_COUNT - 1) * DIGIT_BASE + VAL_MAX + 1);
    localparam int FOLD_STEPS = ((BUCKET_COUNT - 1) * DIGIT_BASE + VAL_MAX) / BUCKET_COUNT;

    localparam int CLEAR_LEN = (BUCKET_COUNT > MAX_CHAIN + 1) ? BUCKET_COUNT : MAX_CHAIN + 1;
    localparam int CLR_W     = $clog2(CLEAR_LEN);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic ANS_COMMIT = 1'b0;
    localparam logic ANS_QUERY  = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_NAME   = 2'd0,
        FN_DIGIT  = 2'd1,
        FN_COMMIT = 2'd2,
        FN_QUERY  = 2'd3
    } t_func;

    typedef enum logic [MODE_W-1:0] {
        MODE_PHONE = 2'd0,
        MODE_NAME  = 2'd1,
        MODE_SUM   = 2'd2
    } t_mode;

    typedef enum logic {
        F_RUN,
        F_FOLD
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLR,
        B_IDLE,
        B_LEN,
        B_HIST1,
        B_HIST2,
        B_OUT
    } t_back_state;

    typedef struct packed {
        logic             is_query;
        logic [BKT_W-1:0] arg;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic             answer_kind;
        logic [BKT_W-1:0] bucket_index;
        logic [LEN_W-1:0] new_chain_length;
        logic [CNT_W-1:0] buckets_with_length;
        logic [LEN_W-1:0] longest_chain;
        logic             table_empty;
        logic             length_saturated;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/hbop_front.sv =====
// Front end: accepts input beats, folds the residues and queues commit and query jobs.
`default_nettype none

module hbop_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [hbop_pkg::MODE_W-1:0]   i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [hbop_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [hbop_pkg::VAL_W-1:0]    i_value,
    input  wire logic                          i_hold,
    input  wire hbop_pkg::t_q_status           i_q_status,
    output logic                               o_push,
    output hbop_pkg::t_job                     o_job
);

    localparam int BKT_W = hbop_pkg::BKT_W;
    localparam int ACC_W = hbop_pkg::ACC_W;

    hbop_pkg::t_front_state r_state, n_state;
    logic [hbop_pkg::MODE_W-1:0] r_mode;
    logic [BKT_W-1:0] r_phone, n_phone;
    logic [BKT_W-1:0] r_name, n_name;
    logic [ACC_W-1:0] r_acc, n_acc;

    logic             accept;
    logic [BKT_W:0]   name_sum;
    logic [BKT_W-1:0] name_red;
    logic [BKT_W:0]   pn_sum;
    logic [BKT_W-1:0] pn_red;
    logic [BKT_W-1:0] bucket;
    logic [ACC_W-1:0] fold_sub;

    assign o_ready = (r_state == hbop_pkg::F_RUN) && !i_hold && !i_q_status.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        name_sum = (BKT_W+1)'(r_name) + (BKT_W+1)'(i_value);
        if (name_sum >= (BKT_W+1)'(hbop_pkg::BUCKET_COUNT)) begin
            name_red = BKT_W'(name_sum - (BKT_W+1)'(hbop_pkg::BUCKET_COUNT));
        end else begin
            name_red = BKT_W'(name_sum);
        end
        pn_sum = (BKT_W+1)'(r_phone) + (BKT_W+1)'(r_name);
        if (pn_sum >= (BKT_W+1)'(hbop_pkg::BUCKET_COUNT)) begin
            pn_red = BKT_W'(pn_sum - (BKT_W+1)'(hbop_pkg::BUCKET_COUNT));
        end else begin
            pn_red = BKT_W'(pn_sum);
        end
        unique case (hbop_pkg::t_mode'(r_mode))
            hbop_pkg::MODE_PHONE: bucket = r_phone;
            hbop_pkg::MODE_NAME:  bucket = r_name;
            default:              bucket = pn_red;
        endcase
    end

    always_comb begin
        fold_sub = '0;
        for (int k = 1; k <= hbop_pkg::FOLD_STEPS; k++) begin
            if (r_acc >= ACC_W'(k * hbop_pkg::BUCKET_COUNT)) begin
                fold_sub = ACC_W'(k * hbop_pkg::BUCKET_COUNT);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_phone = r_phone;
        n_name  = r_name;
        n_acc   = r_acc;
        o_push  = 1'b0;
        o_job   = '0;
        unique case (r_state)
            hbop_pkg::F_RUN: begin
                if (accept) begin
                    unique case (hbop_pkg::t_func'(i_func))
                        hbop_pkg::FN_NAME: begin
                            n_name = name_red;
                        end
                        hbop_pkg::FN_DIGIT: begin
                            n_acc   = (ACC_W'(r_phone) << 3) + (ACC_W'(r_phone) << 1)
                                      + ACC_W'(i_value);
                            n_state = hbop_pkg::F_FOLD;
                        end
                        hbop_pkg::FN_COMMIT: begin
                            o_push         = 1'b1;
                            o_job.is_query = 1'b0;
                            o_job.arg      = bucket;
                            n_phone        = '0;
                            n_name         = '0;
                        end
                        hbop_pkg::FN_QUERY: begin
                            o_push         = 1'b1;
                            o_job.is_query = 1'b1;
                            o_job.arg      = BKT_W'(i_value);
                        end
                    endcase
                end
            end
            hbop_pkg::F_FOLD: begin
                n_phone = BKT_W'(r_acc - fold_sub);
                n_state = hbop_pkg::F_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbop_pkg::F_RUN;
            r_mode  <= '0;
            r_phone <= '0;
            r_name  <= '0;
        end else begin
            r_state <= n_state;
            r_phone <= n_phone;
            r_name  <= n_name;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule

`default_nettype wire

// ===== hdl/hbop_queue.sv =====
// Two-entry job queue between the front end and the back end.
`default_nettype none

module hbop_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire hbop_pkg::t_job   i_job,
    input  wire logic             i_pop,
    output hbop_pkg::t_job        o_head,
    output hbop_pkg::t_q_status   o_status
);

    hbop_pkg::t_job r_mem [hbop_pkg::QUEUE_DEPTH];
    logic [hbop_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [hbop_pkg::QCNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (r_count == hbop_pkg::QCNT_W'(hbop_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hbop_back.sv =====
// Back end: chain length and histogram memories, job sequencer and result register.
`default_nettype none

module hbop_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hbop_pkg::t_q_status i_q_status,
    input  wire hbop_pkg::t_job   i_head,
    output logic                  o_pop,
    output logic                  o_clearing,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output hbop_pkg::t_result     o_result
);

    localparam int BKT_W   = hbop_pkg::BKT_W;
    localparam int LEN_W   = hbop_pkg::LEN_W;
    localparam int CNT_W   = hbop_pkg::CNT_W;
    localparam int HIST_AW = hbop_pkg::HIST_AW;
    localparam int CLR_W   = hbop_pkg::CLR_W;

    logic [LEN_W-1:0] r_chain_mem [hbop_pkg::BUCKET_COUNT];
    logic [CNT_W-1:0] r_hist_mem [hbop_pkg::MAX_CHAIN + 1];

    logic               chain_we, chain_re;
    logic [BKT_W-1:0]   chain_wa, chain_ra;
    logic [LEN_W-1:0]   chain_wd, r_chain_q;
    logic               hist_we, hist_re;
    logic [HIST_AW-1:0] hist_wa, hist_ra_a, hist_ra_b;
    logic [CNT_W-1:0]   hist_wd, r_hist_qa, r_hist_qb;

    hbop_pkg::t_back_state r_state, n_state;
    logic [CLR_W-1:0]   r_clr_cnt, n_clr_cnt;
    hbop_pkg::t_job     r_job, n_job;
    logic [LEN_W-1:0]   r_len_old, n_len_old;
    logic [LEN_W-1:0]   r_len_new, n_len_new;
    logic [LEN_W-1:0]   r_longest, n_longest;
    logic [CNT_W-1:0]   r_used, n_used;
    logic               r_any, n_any;
    hbop_pkg::t_result  r_res, n_res;
    logic               r_o_valid, n_o_valid;
    hbop_pkg::t_result  r_o;
    logic               load;
    logic [LEN_W-1:0]   len_cur;
    logic [CNT_W-1:0]   query_count;
    logic [LEN_W-1:0]   longest_upd;

    assign o_clearing = (r_state == hbop_pkg::B_CLR);
    assign o_valid    = r_o_valid;
    assign o_result   = r_o;
    assign len_cur    = r_chain_q;

    always_comb begin
        if (r_job.arg == '0) begin
            query_count = CNT_W'(hbop_pkg::BUCKET_COUNT) - r_used;
        end else if (r_job.arg <= BKT_W'(hbop_pkg::MAX_CHAIN)) begin
            query_count = r_hist_qa;
        end else begin
            query_count = '0;
        end
        longest_upd = (r_len_new > r_longest) ? r_len_new : r_longest;
    end

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_job     = r_job;
        n_len_old = r_len_old;
        n_len_new = r_len_new;
        n_longest = r_longest;
        n_used    = r_used;
        n_any     = r_any;
        n_res     = r_res;
        o_pop     = 1'b0;
        load      = 1'b0;
        chain_we  = 1'b0;
        chain_wa  = '0;
        chain_wd  = '0;
        chain_re  = 1'b0;
        chain_ra  = '0;
        hist_we   = 1'b0;
        hist_wa   = '0;
        hist_wd   = '0;
        hist_re   = 1'b0;
        hist_ra_a = '0;
        hist_ra_b = '0;
        unique case (r_state)
            hbop_pkg::B_CLR: begin
                chain_we = (r_clr_cnt < CLR_W'(hbop_pkg::BUCKET_COUNT));
                chain_wa = BKT_W'(r_clr_cnt);
                hist_we  = (r_clr_cnt < CLR_W'(hbop_pkg::MAX_CHAIN + 1));
                hist_wa  = HIST_AW'(r_clr_cnt);
                if (r_clr_cnt == CLR_W'(hbop_pkg::CLEAR_LEN - 1)) begin
                    n_state = hbop_pkg::B_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            hbop_pkg::B_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop    = 1'b1;
                    n_job    = i_head;
                    chain_re = !i_head.is_query;
                    chain_ra = i_head.arg;
                    hist_re  = i_head.is_query;
                    if (i_head.arg <= BKT_W'(hbop_pkg::MAX_CHAIN)) begin
                        hist_ra_a = HIST_AW'(i_head.arg);
                    end
                    n_state = hbop_pkg::B_LEN;
                end
            end
            hbop_pkg::B_LEN: begin
                if (r_job.is_query) begin
                    n_res.answer_kind         = hbop_pkg::ANS_QUERY;
                    n_res.bucket_index        = '0;
                    n_res.new_chain_length    = '0;
                    n_res.buckets_with_length = query_count;
                    n_res.longest_chain       = r_longest;
                    n_res.table_empty         = !r_any;
                    n_res.length_saturated    = 1'b0;
                    n_state                   = hbop_pkg::B_OUT;
                end else begin
                    n_any = 1'b1;
                    if (len_cur < LEN_W'(hbop_pkg::MAX_CHAIN)) begin
                        chain_we  = 1'b1;
                        chain_wa  = r_job.arg;
                        chain_wd  = len_cur + 1'b1;
                        hist_re   = 1'b1;
                        hist_ra_a = HIST_AW'(len_cur);
                        hist_ra_b = HIST_AW'(len_cur + 1'b1);
                        n_len_old = len_cur;
                        n_len_new = len_cur + 1'b1;
                        n_state   = hbop_pkg::B_HIST1;
                    end else begin
                        n_res.answer_kind         = hbop_pkg::ANS_COMMIT;
                        n_res.bucket_index        = r_job.arg;
                        n_res.new_chain_length    = len_cur;
                        n_res.buckets_with_length = '0;
                        n_res.longest_chain       = r_longest;
                        n_res.table_empty         = 1'b0;
                        n_res.length_saturated    = 1'b1;
                        n_state                   = hbop_pkg::B_OUT;
                    end
                end
            end
            hbop_pkg::B_HIST1: begin
                if (r_len_old != '0 && r_hist_qa != '0) begin
                    hist_we = 1'b1;
                    hist_wa = HIST_AW'(r_len_old);
                    hist_wd = r_hist_qa - 1'b1;
                end
                if (r_len_old == '0) begin
                    n_used = r_used + 1'b1;
                end
                n_state = hbop_pkg::B_HIST2;
            end
            hbop_pkg::B_HIST2: begin
                hist_we = 1'b1;
                hist_wa = HIST_AW'(r_len_new);
                hist_wd = r_hist_qb + 1'b1;
                n_longest                 = longest_upd;
                n_res.answer_kind         = hbop_pkg::ANS_COMMIT;
                n_res.bucket_index        = r_job.arg;
                n_res.new_chain_length    = r_len_new;
                n_res.buckets_with_length = '0;
                n_res.longest_chain       = longest_upd;
                n_res.table_empty         = 1'b0;
                n_res.length_saturated    = (r_len_new >= LEN_W'(hbop_pkg::MAX_CHAIN));
                n_state                   = hbop_pkg::B_OUT;
            end
            hbop_pkg::B_OUT: begin
                if (!r_o_valid || i_ready) begin
                    load    = 1'b1;
                    n_state = hbop_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = hbop_pkg::B_IDLE;
            end
        endcase
        n_o_valid = (r_o_valid && !i_ready) || load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hbop_pkg::B_CLR;
            r_clr_cnt <= '0;
            r_longest <= '0;
            r_used    <= '0;
            r_any     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_longest <= n_longest;
            r_used    <= n_used;
            r_any     <= n_any;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_len_old <= n_len_old;
        r_len_new <= n_len_new;
        r_res     <= n_res;
        if (load) begin
            r_o <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_we) begin
            r_chain_mem[chain_wa] <= chain_wd;
        end
        if (chain_re) begin
            r_chain_q <= r_chain_mem[chain_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[hist_wa] <= hist_wd;
        end
        if (hist_re) begin
            r_hist_qa <= r_hist_mem[hist_ra_a];
            r_hist_qb <= r_hist_mem[hist_ra_b];
        end
    end

`ifndef SYNTHESIS
    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbop_pkg::B_CLR) |-> !o_pop)
        else $error("job popped during the clearing pass");

    a_chain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_we |-> (chain_wd <= LEN_W'(hbop_pkg::MAX_CHAIN)))
        else $error("chain length written above the bound");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(hbop_pkg::BUCKET_COUNT))
        else $error("occupied bucket count exceeds the bucket count");

    a_longest_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_longest >= $past(r_longest)))
        else $error("longest chain decreased");
`endif

endmodule

`default_nettype wire

// ===== hdl/hash_bucket_occupancy_profiler.sv =====
// Top level of the hash bucket occupancy profiler.
//
// Input beats (i_valid/o_ready) carry i_func and i_value: name bytes and phone
// digits fold into running residues, a commit adds one entry to the chosen
// bucket, and a query asks how many buckets have a given chain length.
// Only commits and queries produce a result beat on o_valid/i_ready.
// A phone digit passes through a fold state in the front end, where the
// digit residue is reduced by a compare-and-subtract step.
// Commit and query jobs pass through a two-entry queue to the back end.
// A commit reads the chain length memory, makes two histogram updates through
// the single histogram write port and loads the result; a query reads the
// histogram memory and a saturated commit the chain length memory, and both
// load the result with no histogram update. A held result keeps the back end
// in its output state; the front end keeps folding and queuing until the
// queue is full.
// After reset the back end clears the chain length and histogram memories,
// one entry a cycle, with o_ready low. The hash mode register is
// written through i_cfg_we/i_cfg_data and resets to hashing by phone number.
`default_nettype none

module hash_bucket_occupancy_profiler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [hbop_pkg::MODE_W-1:0]   i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [hbop_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [hbop_pkg::VAL_W-1:0]    i_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_answer_kind,
    output logic [hbop_pkg::BKT_W-1:0]         o_bucket_index,
    output logic [hbop_pkg::LEN_W-1:0]         o_new_chain_length,
    output logic [hbop_pkg::CNT_W-1:0]         o_buckets_with_length,
    output logic [hbop_pkg::LEN_W-1:0]         o_longest_chain,
    output logic                               o_table_empty,
    output logic                               o_length_saturated
);

    logic                push;
    logic                pop;
    logic                clearing;
    hbop_pkg::t_job      push_job;
    hbop_pkg::t_job      head_job;
    hbop_pkg::t_q_status q_status;
    hbop_pkg::t_result   result;

    hbop_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_hold     (clearing),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    hbop_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    hbop_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head_job),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (result)
    );

    assign o_answer_kind         = result.answer_kind;
    assign o_bucket_index        = result.bucket_index;
    assign o_new_chain_length    = result.new_chain_length;
    assign o_buckets_with_length = result.buckets_with_length;
    assign o_longest_chain       = result.longest_chain;
    assign o_table_empty         = result.table_empty;
    assign o_length_saturated    = result.length_saturated;

endmodule

`default_nettype wire
